FILE: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping of the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned GROUP_W     = 3 * BYTE_W;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;  // '='

    // Number of '=' characters closing a group
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } pad_t;

    // One group of three bytes on its way from the front to the back
    typedef struct packed {
        logic [GROUP_W-1:0] bytes;  // first byte in the top bits, missing bytes zero
        pad_t               pad;
        logic               last;
    } group_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [BYTE_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [BYTE_W-1:0] c;
        begin
            c = '0;
            if (v < 6'd26)
            begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                c = 8'h61 + {2'b00, v - 6'd26};
            end
            else if (v < 6'd62)
            begin
                c = 8'h30 + {2'b00, v - 6'd52};
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

FILE: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Gathers source bytes into groups of three and pushes complete or final
// groups, with their padding count, into the group queue.
// ----------------------------------------------------------------------------
module b64e_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] in_byte
    input  logic                    s_tlast,   // is_last
    input  logic                    q_full,
    output logic                    q_push,
    output b64e_pkg::group_t        q_group
);
    import b64e_pkg::*;

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        q_push        = 1'b0;
        q_group.bytes = '0;
        q_group.pad   = PAD_NONE;
        q_group.last  = s_tlast;
        case (cnt_reg)
            2'd1:
            begin
                q_group.bytes = {pend_reg[15:8], s_tdata, 8'h00};
                q_group.pad   = PAD_ONE;
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        q_push   = 1'b1;
                        cnt_next = 2'd0;
                    end
                    else
                    begin
                        pend_next = {pend_reg[15:8], s_tdata};
                        cnt_next  = 2'd2;
                    end
                end
            end
            2'd2:
            begin
                q_group.bytes = {pend_reg, s_tdata};
                q_group.pad   = PAD_NONE;
                if (accept)
                begin
                    q_push   = 1'b1;
                    cnt_next = 2'd0;
                end
            end
            default:
            begin
                // empty; an unreachable count of three also counts as empty
                q_group.bytes = {s_tdata, 16'h0000};
                q_group.pad   = PAD_TWO;
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        q_push   = 1'b1;
                        cnt_next = 2'd0;
                    end
                    else
                    begin
                        pend_next = {s_tdata, 8'h00};
                        cnt_next  = 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small first-in first-out queue of groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue
#(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64e_pkg::group_t    push_group,
    input  logic                pop,
    output b64e_pkg::group_t    head_group,
    output logic                full,
    output logic                empty
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign empty      = (cnt_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_group = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

FILE: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes groups from the queue and sends their four characters, one per
// cycle while m_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module b64e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  b64e_pkg::group_t    q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_char
    output logic                m_tlast    // end_of_message
);
    import b64e_pkg::*;

    group_t       grp_reg, grp_next;
    logic [1:0]   idx_reg, idx_next;
    logic         busy_reg, busy_next;
    logic         ovalid_reg, ovalid_next;
    logic [7:0]   ochar_reg, ochar_next;
    logic         olast_reg, olast_next;
    logic         adv;
    logic [5:0]   sextet;
    logic         is_pad;

    assign adv = busy_reg && (!ovalid_reg || m_tready);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.bytes[23:18];
            2'd1:    sextet = grp_reg.bytes[17:12];
            2'd2:    sextet = grp_reg.bytes[11:6];
            default: sextet = grp_reg.bytes[5:0];
        endcase
        case (idx_reg)
            2'd2:    is_pad = (grp_reg.pad == PAD_TWO);
            2'd3:    is_pad = (grp_reg.pad != PAD_NONE);
            default: is_pad = 1'b0;
        endcase
    end

    always_comb
    begin
        grp_next    = grp_reg;
        idx_next    = idx_reg;
        busy_next   = busy_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !m_tready;
        q_pop       = 1'b0;
        if (adv)
        begin
            ovalid_next = 1'b1;
            ochar_next  = is_pad ? PAD_CHAR : sextet_char(sextet);
            olast_next  = grp_reg.last && (idx_reg == 2'd3);
            idx_next    = idx_reg + 1'b1;
            if (idx_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
        // reload as soon as the current group has sent its last character
        if ((!busy_reg || (adv && idx_reg == 2'd3)) && !q_empty)
        begin
            q_pop     = 1'b1;
            grp_next  = q_head;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: rtl/base64_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_encoder_top
// Streaming Base64 encoder (standard alphabet, '=' padding).
//
// Usage:
//   Slave channel s_*: one source byte per transaction in s_tdata, s_tlast
//   set on the final byte of a message. Messages are never empty.
//   Master channel m_*: one ASCII character per transaction in m_tdata;
//   m_tlast is set on the fourth character of the message's final group.
//   Every group of three bytes, and every short final group of one or two
//   bytes, becomes four characters (short groups end in "=" or "==").
// Path: the transaction that completes a group writes it into the queue
//   at its own edge; when the back is idle it then loads the group from
//   the queue and registers the first character, which raises m_tvalid.
// Throughput: the back sends one character per cycle while m_tready is
//   high. s_tready stays high while the group queue has room, which the
//   back's one-character-per-cycle drain sets. A message of single bytes
//   costs four characters per byte.
// Reset: rst_n clears the gathered count, the queue and the output valid;
//   any partial group is dropped.
// Stall: when m_tready is low the output register holds its character, the
//   queue fills, and s_tready falls once QUEUE_DEPTH groups are waiting.
// ----------------------------------------------------------------------------
module base64_encoder_top
#(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // end_of_message
);
    import b64e_pkg::*;

    group_t push_group;
    group_t head_group;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    // front: gathers bytes into groups
    b64e_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_group  (push_group)
    );

    // group queue decouples gathering from character output
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (push_group),
        .pop        (q_pop),
        .head_group (head_group),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: four characters per group, one per cycle while m_tready is high
    b64e_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (head_group),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/sv/tb_base64_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_base64_encoder_top
// Self-checking bench for the streaming Base64 encoder. Source bytes go in as
// directed messages, then messages of random length. Each accepted byte is
// run through a cycle-free model of the encoder. Every character that leaves
// the master channel is compared with the oldest predicted character. Both
// channels idle at random, and the sink stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_base64_encoder_top;

    import b64e_pkg::*;

    // One predicted character on the master channel
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              eom;
    } b64_char_t;

    // ------------------------------------------------------------------------
    // Encoder model plus the queue of characters it predicts
    // ------------------------------------------------------------------------
    class b64_scoreboard;
        logic [15:0] held_bytes;   // first gathered byte in [15:8], second in [7:0]
        logic [1:0]  held_count;
        b64_char_t   char_q[$];
        string       symbols;
        int          errors;

        function new();
            held_bytes = '0;
            held_count = '0;
            errors     = 0;
            symbols    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        endfunction

        function logic [BYTE_W-1:0] sextet_ascii(input logic [5:0] v);
            return BYTE_W'(symbols[v]);
        endfunction

        function void push_char(input logic [BYTE_W-1:0] c, input logic eom);
            b64_char_t e;
            e.ch  = c;
            e.eom = eom;
            char_q.push_back(e);
        endfunction

        // Called once per accepted slave transaction
        function void note_byte(input logic [7:0] b, input logic last);
            logic [7:0] b0;
            logic [7:0] b1;
            logic [1:0] n;
            n  = (held_count == 2'd3) ? 2'd0 : held_count;
            b0 = held_bytes[15:8];
            b1 = held_bytes[7:0];
            if (n < 2'd2 && !last)
            begin
                // still gathering: nothing comes out
                if (n == 2'd0)
                begin
                    held_bytes = {b, 8'h00};
                end
                else
                begin
                    held_bytes[7:0] = b;
                end
                held_count = n + 2'd1;
                return;
            end
            case (n)
                2'd2:
                begin
                    push_char(sextet_ascii(b0[7:2]), 1'b0);
                    push_char(sextet_ascii({b0[1:0], b1[7:4]}), 1'b0);
                    push_char(sextet_ascii({b1[3:0], b[7:6]}), 1'b0);
                    push_char(sextet_ascii(b[5:0]), last);
                end
                2'd1:
                begin
                    push_char(sextet_ascii(b0[7:2]), 1'b0);
                    push_char(sextet_ascii({b0[1:0], b[7:4]}), 1'b0);
                    push_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
                    push_char(PAD_CHAR, last);
                end
                default:
                begin
                    push_char(sextet_ascii(b[7:2]), 1'b0);
                    push_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, last);
                end
            endcase
            held_bytes = '0;
            held_count = '0;
        endfunction

        // Called once per accepted master transaction
        function void check_char(input logic [7:0] c, input logic eom);
            b64_char_t e;
            if (char_q.size() == 0)
            begin
                $error("unexpected character: out_char actual 0x%02h, end_of_message actual %0b",
                       c, eom);
                errors++;
                return;
            end
            e = char_q.pop_front();
            if (c !== e.ch)
            begin
                $error("out_char: expected 0x%02h, actual 0x%02h", e.ch, c);
                errors++;
            end
            if (eom !== e.eom)
            begin
                $error("end_of_message: expected %0b, actual %0b", e.eom, eom);
                errors++;
            end
        endfunction

        function int waiting();
            return char_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;            // end_of_message

    b64_scoreboard sb = new();

    // source-side idling on/off, redrawn per message
    bit src_idle  = 1'b0;
    // sink-side state
    bit sink_idle = 1'b0;
    int sink_hold = 0;
    int chars_seen = 0;
    int bytes_sent = 0;

    base64_encoder_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2-unit clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #400000;
        $display("base64_encoder_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink: checks every master transaction, then draws its next stall.
    // Outputs are read at the edge, before the DUT's updates land.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_char(m_tdata, m_tlast);
            chars_seen++;
            // switch between idling and full-rate stretches now and then
            if (chars_seen % 48 == 0)
            begin
                sink_idle = ($urandom_range(0, 2) != 0);
            end
            if (chars_seen == 100)
            begin
                // long hold-off: group queue fills and s_tready must drop
                sink_hold = 300;
            end
            else
            begin
                sink_hold = sink_idle ? $urandom_range(0, 13) : 0;
            end
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
        end
        m_tready <= (sink_hold == 0);
    end

    // ------------------------------------------------------------------------
    // Source: one slave transaction per call, with a random lead-in gap when src_idle is set.
    // Entered right after a rising edge; leaves right after the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Message of random bytes; length mostly short, sometimes long
    task automatic send_random_message();
        int len;
        if ($urandom_range(0, 7) == 0)
        begin
            len = $urandom_range(9, 40);
        end
        else
        begin
            len = $urandom_range(1, 8);
        end
        src_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-byte messages at both extremes ("AA==", "/w==")
        src_idle = 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte short groups ("AAA=", "//8=")
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        src_idle = 1'b1;
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full group closing the message: "++++" then "////"
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full group mid-message, then a one-byte tail: "TWFu" "AA=="
        src_idle = 1'b0;
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h00, 1'b1);
        // full group, then a two-byte tail
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);

        // Random messages
        while (bytes_sent < 340)
        begin
            send_random_message();
        end
        s_tvalid <= 1'b0;

        // drain: everything predicted must come out, then watch for strays
        while (sb.waiting() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.waiting() == 0)
        begin
            $display("base64_encoder_top: match");
        end
        else
        begin
            $display("base64_encoder_top: mismatch");
        end
        $finish;
    end

endmodule
